@@ rtl/core/rbd_pkg.sv @@
// Shared types and constants for the RGB 2x2 box downsampler.
package rbd_pkg;

	localparam int CFG_W = 13;
	localparam int ROW_W = 12;
	localparam int MAX_IN_HEIGHT = 4096;
	localparam int SAMPLE_W = 8;
	localparam int PAIR_W = SAMPLE_W + 1;

	localparam logic REG_IN_WIDTH = 1'b0;
	localparam logic REG_IN_HEIGHT = 1'b1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] in_red;
		logic [SAMPLE_W-1:0] in_green;
		logic [SAMPLE_W-1:0] in_blue;
	} in_pix_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] out_red;
		logic [SAMPLE_W-1:0] out_green;
		logic [SAMPLE_W-1:0] out_blue;
		logic                frame_last;
	} out_pix_t;

	// One line store word: three horizontal pair sums.
	typedef struct packed {
		logic [PAIR_W-1:0] blue;
		logic [PAIR_W-1:0] green;
		logic [PAIR_W-1:0] red;
	} pair_word_t;

	// Control carried by the stage between the lanes and the output register.
	typedef struct packed {
		logic valid;
		logic last;
		logic use_above;
	} s1_ctrl_t;

endpackage

@@ rtl/core/rbd_lane.sv @@
// One color channel: horizontal pair sum, then the vertical sum and divide by four.
module rbd_lane (
	input  logic                         clk,
	input  logic [rbd_pkg::SAMPLE_W-1:0] pix,
	input  logic [rbd_pkg::SAMPLE_W-1:0] left,
	input  logic                         use_left,
	input  logic                         load,
	input  logic [rbd_pkg::PAIR_W-1:0]   above,
	input  logic                         use_above,
	output logic [rbd_pkg::PAIR_W-1:0]   pair,
	output logic [rbd_pkg::SAMPLE_W-1:0] avg
);
	import rbd_pkg::*;

	logic [PAIR_W-1:0]   pair_s1;
	logic [PAIR_W-1:0]   above_m;
	logic [PAIR_W:0]     total;

	// A pixel on the right edge of an odd-width row pairs with zero.
	assign pair = {1'b0, (use_left ? left : '0)} + {1'b0, pix};

	always_ff @(posedge clk) begin
		if (load) begin
			pair_s1 <= pair;
		end
	end

	assign above_m = use_above ? above : '0;
	assign total   = {1'b0, above_m} + {1'b0, pair_s1};
	assign avg     = total[PAIR_W:2];

endmodule

@@ rtl/core/rbd_merge.sv @@
// Output register that merges the three lane results and the frame flag.
module rbd_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rbd_pkg::s1_ctrl_t            ctrl_s1,
	input  logic [rbd_pkg::SAMPLE_W-1:0] avg_red,
	input  logic [rbd_pkg::SAMPLE_W-1:0] avg_green,
	input  logic [rbd_pkg::SAMPLE_W-1:0] avg_blue,
	input  logic                         res_ready,
	output logic                         res_valid,
	output rbd_pkg::out_pix_t            res,
	output logic                         adv
);
	import rbd_pkg::*;

	logic     valid_q;
	out_pix_t res_q;

	assign adv = !valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctrl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl_s1.valid) begin
			res_q.out_red    <= avg_red;
			res_q.out_green  <= avg_green;
			res_q.out_blue   <= avg_blue;
			res_q.frame_last <= ctrl_s1.last;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

@@ rtl/core/rgb_box_downsample_by_two_top.sv @@
// Top level of the RGB 2x2 box downsampler with its line store and counters.
//
//  channel | signals                        | moves
//  --------+--------------------------------+-------------------------------
//  pix     | pix_valid, pix_ready, pix      | one input pixel, raster order
//  res     | res_valid, res_ready, res      | one output pixel with last flag
//  cfg     | cfg_we, cfg_index, cfg_data    | width and height writes
//
// One pixel request is taken every clock while results are drained.
// After the request that completes its window, a result passes the registered
// line store read and pair sums, then the output register.
// The line store is not cleared; an odd row only reads slots its even row wrote.
// A stalled result holds a full stage behind it, which then holds pix_ready low.
// A configuration write restarts the frame.
module rgb_box_downsample_by_two_top #(
	parameter int MAX_IN_WIDTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  rbd_pkg::in_pix_t          pix,
	output logic                      res_valid,
	input  logic                      res_ready,
	output rbd_pkg::out_pix_t         res,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [rbd_pkg::CFG_W-1:0] cfg_data
);
	import rbd_pkg::*;

	localparam int LINE_DEPTH = (MAX_IN_WIDTH + 1) / 2;
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CW = $clog2(MAX_IN_WIDTH);
	localparam int WW = $clog2(MAX_IN_WIDTH + 1);

	logic [CFG_W-1:0]    in_width_q;
	logic [CFG_W-1:0]    in_height_q;
	logic [WW-1:0]       eff_w;
	logic [CFG_W-1:0]    eff_h;
	logic [CW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;
	in_pix_t             left_q;
	s1_ctrl_t            ctrl_s1;
	pair_word_t          line_mem [LINE_DEPTH];
	pair_word_t          rdata_q;
	pair_word_t          pair;
	logic [AW-1:0]       slot;
	logic                accept;
	logic                adv;
	logic                s1_load;
	logic                col_odd;
	logic                row_odd;
	logic                col_end;
	logic                row_end;
	logic                have_pair;
	logic                mem_we;
	logic                mem_re;
	logic                emit;
	logic [SAMPLE_W-1:0] avg_red;
	logic [SAMPLE_W-1:0] avg_green;
	logic [SAMPLE_W-1:0] avg_blue;

	// Out-of-range sizes clamp into the supported range.
	always_comb begin
		if (in_width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(in_width_q) > 32'(MAX_IN_WIDTH)) begin
			eff_w = WW'(MAX_IN_WIDTH);
		end else begin
			eff_w = WW'(in_width_q);
		end
		if (in_height_q == '0) begin
			eff_h = CFG_W'(1);
		end else if (32'(in_height_q) > 32'(MAX_IN_HEIGHT)) begin
			eff_h = CFG_W'(MAX_IN_HEIGHT);
		end else begin
			eff_h = in_height_q;
		end
	end

	assign s1_load   = !ctrl_s1.valid || adv;
	assign pix_ready = s1_load;
	assign accept    = pix_valid && pix_ready;

	assign col_odd   = col_q[0];
	assign row_odd   = row_q[0];
	assign col_end   = (WW'(col_q) + WW'(1)) == eff_w;
	assign row_end   = (CFG_W'(row_q) + CFG_W'(1)) == eff_h;
	assign have_pair = col_odd || col_end;
	assign slot      = AW'(col_q >> 1);
	assign mem_we    = accept && have_pair && !row_odd && !row_end;
	assign mem_re    = accept && have_pair && row_odd;
	assign emit      = have_pair && (row_odd || row_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= CFG_W'(1);
			in_height_q <= CFG_W'(1);
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_WIDTH:  in_width_q  <= cfg_data;
				REG_IN_HEIGHT: in_height_q <= cfg_data;
				default:       in_width_q  <= in_width_q;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			// The last pixel of a frame leaves the left pixel cleared for the next one.
			if (col_end && row_end) begin
				left_q <= '0;
			end else if (!col_odd) begin
				left_q <= pix;
			end
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (s1_load) begin
			ctrl_s1.valid     <= accept && emit;
			ctrl_s1.last      <= col_end && row_end;
			ctrl_s1.use_above <= row_odd;
		end
	end

	// Even rows other than the last write their pair sums; odd rows read them back through a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[slot] <= pair;
		end
		if (mem_re) begin
			rdata_q <= line_mem[slot];
		end
	end

	rbd_lane u_lane_red (
		.clk       (clk),
		.pix       (pix.in_red),
		.left      (left_q.in_red),
		.use_left  (col_odd),
		.load      (accept),
		.above     (rdata_q.red),
		.use_above (ctrl_s1.use_above),
		.pair      (pair.red),
		.avg       (avg_red)
	);

	rbd_lane u_lane_green (
		.clk       (clk),
		.pix       (pix.in_green),
		.left      (left_q.in_green),
		.use_left  (col_odd),
		.load      (accept),
		.above     (rdata_q.green),
		.use_above (ctrl_s1.use_above),
		.pair      (pair.green),
		.avg       (avg_green)
	);

	rbd_lane u_lane_blue (
		.clk       (clk),
		.pix       (pix.in_blue),
		.left      (left_q.in_blue),
		.use_left  (col_odd),
		.load      (accept),
		.above     (rdata_q.blue),
		.use_above (ctrl_s1.use_above),
		.pair      (pair.blue),
		.avg       (avg_blue)
	);

	rbd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s1   (ctrl_s1),
		.avg_red   (avg_red),
		.avg_green (avg_green),
		.avg_blue  (avg_blue),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv)
	);

`ifndef SYNTHESIS
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(col_q) < eff_w))
		else $error("column count ran past the row width");

	a_rw_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("line store written and read in the same cycle");

	a_read_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s1.valid && !adv) |=> $stable(rdata_q))
		else $error("line store data changed under a stalled stage");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!ctrl_s1.valid || adv))
		else $error("request taken while the stage ahead was full");
`endif

endmodule
